// ===== hw/rtl/dcpvr_pkg.sv =====
// Package for the dual-channel PWM voltage regulator.
// Holds the constants, the command and configuration types and the mode helpers.
// It depends on nothing else.
`timescale 1ns / 1ps

package dcpvr_pkg;

	localparam logic [15:0] INNER_PERIOD    = 16'd1024;
	localparam logic [15:0] EXT_PERIOD      = 16'd1024;
	localparam logic [15:0] EXT_DUTY_MAX    = 16'd1024;
	localparam logic [15:0] EXT_DUTY_MIN    = 16'd0;
	localparam int          CHANNELS_FITTED = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS = 32;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam logic [1:0] MODE_INNER = 2'd0;
	localparam logic [1:0] MODE_EXT   = 2'd1;
	localparam logic [1:0] MODE_BOTH  = 2'd2;

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_CONTROL = 2'd1;
	localparam logic [1:0] KIND_STOP    = 2'd2;

	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_TARGET_LOW     = 3'd0;
	localparam logic [2:0] REG_TARGET_MID     = 3'd1;
	localparam logic [2:0] REG_TARGET_HIGH    = 3'd2;
	localparam logic [2:0] REG_TARGET_PREFIRE = 3'd3;
	localparam logic [2:0] REG_EXT_TARGET     = 3'd4;
	localparam logic [2:0] REG_RMS_MODE       = 3'd5;
	localparam logic [2:0] REG_INNER_DUTY_MAX = 3'd6;
	localparam logic [2:0] REG_INNER_DUTY_MIN = 3'd7;

	localparam logic [15:0] RST_TARGET_LOW     = 16'd3300;
	localparam logic [15:0] RST_TARGET_MID     = 16'd3600;
	localparam logic [15:0] RST_TARGET_HIGH    = 16'd3900;
	localparam logic [15:0] RST_TARGET_PREFIRE = 16'd2000;
	localparam logic [15:0] RST_EXT_TARGET     = 16'd3600;
	localparam logic [15:0] RST_INNER_DUTY_MAX = 16'd1024;

	localparam logic [1:0] LEVEL_LOW  = 2'd0;
	localparam logic [1:0] LEVEL_MID  = 2'd1;
	localparam logic [1:0] LEVEL_HIGH = 2'd2;

	typedef struct packed {
		logic [15:0] target_low;
		logic [15:0] target_mid;
		logic [15:0] target_high;
		logic [15:0] target_prefire;
		logic [15:0] ext_target;
		logic [1:0]  rms_mode;
		logic [15:0] inner_duty_max;
		logic [15:0] inner_duty_min;
	} cfg_t;

	typedef struct packed {
		logic        is_start;
		logic        is_control;
		logic        is_stop;
		logic        prefire;
		logic [1:0]  power_level;
		logic [15:0] inner_voltage;
		logic [15:0] ext_voltage;
	} cmd_t;

	function automatic logic has_inner(input logic [1:0] mode);
		return mode != MODE_EXT;
	endfunction

	function automatic logic has_ext(input logic [1:0] mode);
		return (mode == MODE_EXT) || (mode == MODE_BOTH);
	endfunction

	function automatic logic [1:0] next_mode(input logic [1:0] mode);
		logic [1:0] nm;
		if (CHANNELS_FITTED == 1) begin
			nm = MODE_INNER;
		end else if (CHANNELS_FITTED == 2) begin
			nm = MODE_EXT;
		end else if (mode == MODE_INNER) begin
			nm = MODE_EXT;
		end else if (mode == MODE_EXT) begin
			nm = MODE_BOTH;
		end else begin
			nm = MODE_INNER;
		end
		return nm;
	endfunction

endpackage

// ===== hw/rtl/dcpvr_front.sv =====
// Front end of the regulator: takes input transactions and classifies them.
// Depends on dcpvr_pkg; feeds the command queue.
`timescale 1ns / 1ps

module dcpvr_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // prefire, power_level, inner_voltage, ext_voltage
	input  logic [1:0]        s_tuser,   // kind
	input  logic              q_full,
	output logic              q_push,
	output dcpvr_pkg::cmd_t   q_cmd
);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd               = '0;
		q_cmd.prefire       = s_tdata[0];
		q_cmd.power_level   = s_tdata[2:1];
		q_cmd.inner_voltage = s_tdata[18:3];
		q_cmd.ext_voltage   = s_tdata[34:19];
		case (s_tuser)
			dcpvr_pkg::KIND_START: begin
				q_cmd.is_start = 1'b1;
			end
			dcpvr_pkg::KIND_CONTROL: begin
				q_cmd.is_control = 1'b1;
			end
			dcpvr_pkg::KIND_STOP: begin
				q_cmd.is_stop = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/dcpvr_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on dcpvr_pkg for the command type and the depth.
`timescale 1ns / 1ps

module dcpvr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcpvr_pkg::cmd_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output dcpvr_pkg::cmd_t pop_data
);

	dcpvr_pkg::cmd_t                        mem_q [dcpvr_pkg::QUEUE_DEPTH];
	logic [dcpvr_pkg::QUEUE_AW-1:0]         wr_q;
	logic [dcpvr_pkg::QUEUE_AW-1:0]         rd_q;
	logic [dcpvr_pkg::QUEUE_CW-1:0]         cnt_q;

	localparam logic [dcpvr_pkg::QUEUE_AW-1:0] LAST =
		dcpvr_pkg::QUEUE_AW'(dcpvr_pkg::QUEUE_DEPTH - 1);
	localparam logic [dcpvr_pkg::QUEUE_CW-1:0] DEPTH_C =
		dcpvr_pkg::QUEUE_CW'(dcpvr_pkg::QUEUE_DEPTH);

	assign full      = cnt_q == DEPTH_C;
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/dcpvr_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on dcpvr_pkg for the step count; used by the back end.
`timescale 1ns / 1ps

module dcpvr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic                        busy_q;
	logic                        done_q;
	logic [dcpvr_pkg::DIV_CW-1:0] cnt_q;
	logic [15:0]                 rem_q;
	logic [31:0]                 quo_q;
	logic [15:0]                 den_q;
	logic [16:0]                 trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dcpvr_pkg::DIV_CW'(dcpvr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

endmodule

// ===== hw/rtl/dcpvr_back.sv =====
// Back end of the regulator: holds channel state, runs start, control and stop
// commands and keeps the result register. Depends on dcpvr_pkg and dcpvr_div.
`timescale 1ns / 1ps

module dcpvr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dcpvr_pkg::cfg_t   cfg,
	input  logic              q_not_empty,
	input  dcpvr_pkg::cmd_t   q_cmd,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_DIVGO  = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t          state_q;
	dcpvr_pkg::cmd_t cmd_q;
	logic [1:0]      mode_q;
	logic [15:0]     inner_tgt_q;
	logic [15:0]     ext_tgt_q;
	logic [15:0]     inner_duty_q;
	logic [15:0]     ext_duty_q;
	logic            inner_on_q;
	logic            ext_on_q;
	logic            adjust_q;
	logic            ch_q;
	logic            pass_q;
	logic [15:0]     dq_q;
	logic [31:0]     prod_q;
	logic            m_valid_q;
	logic [39:0]     m_data_q;

	logic [1:0]  mode_nx;
	logic [15:0] tgt;
	logic [15:0] meas;
	logic [15:0] dmax;
	logic [15:0] dmin;
	logic        rms;
	logic [15:0] mul_a;
	logic [31:0] mult;
	logic        div_done;
	logic [31:0] quo;
	logic        fin;
	logic        again;
	logic [15:0] fin_duty;

	assign mode_nx  = dcpvr_pkg::next_mode(mode_q);
	assign q_pop    = (state_q == ST_IDLE) && q_not_empty && !m_valid_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_comb begin
		tgt   = ch_q ? ext_tgt_q : inner_tgt_q;
		meas  = ch_q ? cmd_q.ext_voltage : cmd_q.inner_voltage;
		dmax  = ch_q ? dcpvr_pkg::EXT_DUTY_MAX : cfg.inner_duty_max;
		dmin  = ch_q ? dcpvr_pkg::EXT_DUTY_MIN : cfg.inner_duty_min;
		rms   = ch_q ? cfg.rms_mode[1] : cfg.rms_mode[0];
		mul_a = pass_q ? dq_q : (ch_q ? dcpvr_pkg::EXT_PERIOD : dcpvr_pkg::INNER_PERIOD);
		mult  = 32'(mul_a) * 32'(tgt);
		fin      = 1'b0;
		again    = 1'b0;
		fin_duty = dmax;
		if (state_q == ST_MUL && meas == '0) begin
			fin = 1'b1;
		end else if (state_q == ST_DIV && div_done) begin
			if (quo[31:16] != '0) begin
				fin = 1'b1;
			end else if (!pass_q && rms) begin
				again = 1'b1;
			end else begin
				fin = 1'b1;
				if (quo[15:0] >= dmax) begin
					fin_duty = dmax;
				end else if (quo[15:0] < dmin) begin
					fin_duty = dmin;
				end else begin
					fin_duty = quo[15:0];
				end
			end
		end
	end

	dcpvr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIVGO),
		.num    (prod_q),
		.den    (meas),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= dcpvr_pkg::MODE_BOTH;
			inner_tgt_q  <= dcpvr_pkg::RST_TARGET_LOW;
			ext_tgt_q    <= '0;
			inner_duty_q <= '0;
			ext_duty_q   <= '0;
			inner_on_q   <= 1'b0;
			ext_on_q     <= 1'b0;
			adjust_q     <= 1'b0;
			ch_q         <= 1'b0;
			pass_q       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						adjust_q <= 1'b0;
						state_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_RESULT;
					if (cmd_q.is_start) begin
						mode_q <= mode_nx;
						if (dcpvr_pkg::has_inner(mode_nx)) begin
							inner_duty_q <= dcpvr_pkg::INNER_PERIOD >> 1;
							inner_on_q   <= 1'b1;
							if (cmd_q.prefire) begin
								inner_tgt_q <= cfg.target_prefire;
							end else if (cmd_q.power_level == dcpvr_pkg::LEVEL_LOW) begin
								inner_tgt_q <= cfg.target_low;
							end else if (cmd_q.power_level == dcpvr_pkg::LEVEL_MID) begin
								inner_tgt_q <= cfg.target_mid;
							end else if (cmd_q.power_level == dcpvr_pkg::LEVEL_HIGH) begin
								inner_tgt_q <= cfg.target_high;
							end
						end
						if (dcpvr_pkg::has_ext(mode_nx)) begin
							ext_duty_q <= dcpvr_pkg::EXT_PERIOD >> 1;
							ext_tgt_q  <= cfg.ext_target;
							ext_on_q   <= 1'b1;
							adjust_q   <= 1'b1;
						end
					end else if (cmd_q.is_control) begin
						ch_q     <= !dcpvr_pkg::has_inner(mode_q);
						pass_q   <= 1'b0;
						adjust_q <= dcpvr_pkg::has_ext(mode_q);
						state_q  <= ST_MUL;
					end else if (cmd_q.is_stop) begin
						if (dcpvr_pkg::has_inner(mode_q)) begin
							inner_duty_q <= '0;
							inner_on_q   <= 1'b0;
						end
						if (dcpvr_pkg::has_ext(mode_q)) begin
							ext_duty_q <= '0;
							ext_on_q   <= 1'b0;
						end
					end
				end
				ST_MUL, ST_DIV: begin
					if (again) begin
						pass_q  <= 1'b1;
						state_q <= ST_MUL;
					end else if (fin) begin
						if (ch_q) begin
							ext_duty_q <= fin_duty;
						end else begin
							inner_duty_q <= fin_duty;
						end
						if (!ch_q && dcpvr_pkg::has_ext(mode_q)) begin
							ch_q    <= 1'b1;
							pass_q  <= 1'b0;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_RESULT;
						end
					end else if (state_q == ST_MUL) begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_RESULT: begin
					m_valid_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mult;
		end
		if (again) begin
			dq_q <= quo[15:0];
		end
		if (state_q == ST_RESULT) begin
			m_data_q <= {3'b000, adjust_q, mode_q, ext_on_q, inner_on_q,
				ext_duty_q, inner_duty_q};
		end
	end

endmodule

// ===== hw/rtl/dual_channel_pwm_voltage_regulator.sv =====
// Top level of the dual-channel PWM voltage regulator: register port, front end,
// command queue and back end. Depends on dcpvr_pkg and all dcpvr_* modules.
//
// Channel   Direction  Handshake                     Content
// s_*       in         tvalid/tready                 one command transaction
// m_*       out        tvalid/tready                 one result transaction per command
// APB       in/out     psel/penable, pready high     eight configuration registers
//
// Start, stop and unknown commands go from decode straight to the result state, and the
// back end waits for each result to be taken before it pops the next command. A control
// command runs each active channel through the shared serial divider, one or two
// divisions per active channel and none for a zero measurement.
// Reset clears the control and configuration state at once; data registers are not reset and there is no clearing pass.
// The queue holds two commands; input stalls once both wait behind a busy back end
// or a result that has not been taken.
`timescale 1ns / 1ps

module dual_channel_pwm_voltage_regulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // prefire, power_level, inner_voltage, ext_voltage
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // inner_duty, ext_duty, inner_on, ext_on, channel_mode,
	                               // ext_adjust_request
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dcpvr_pkg::cfg_t cfg_q;
	dcpvr_pkg::cmd_t push_cmd;
	dcpvr_pkg::cmd_t pop_cmd;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_not_empty;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_low     <= dcpvr_pkg::RST_TARGET_LOW;
			cfg_q.target_mid     <= dcpvr_pkg::RST_TARGET_MID;
			cfg_q.target_high    <= dcpvr_pkg::RST_TARGET_HIGH;
			cfg_q.target_prefire <= dcpvr_pkg::RST_TARGET_PREFIRE;
			cfg_q.ext_target     <= dcpvr_pkg::RST_EXT_TARGET;
			cfg_q.rms_mode       <= '0;
			cfg_q.inner_duty_max <= dcpvr_pkg::RST_INNER_DUTY_MAX;
			cfg_q.inner_duty_min <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				dcpvr_pkg::REG_TARGET_LOW:     cfg_q.target_low     <= pwdata[15:0];
				dcpvr_pkg::REG_TARGET_MID:     cfg_q.target_mid     <= pwdata[15:0];
				dcpvr_pkg::REG_TARGET_HIGH:    cfg_q.target_high    <= pwdata[15:0];
				dcpvr_pkg::REG_TARGET_PREFIRE: cfg_q.target_prefire <= pwdata[15:0];
				dcpvr_pkg::REG_EXT_TARGET:     cfg_q.ext_target     <= pwdata[15:0];
				dcpvr_pkg::REG_RMS_MODE:       cfg_q.rms_mode       <= pwdata[1:0];
				dcpvr_pkg::REG_INNER_DUTY_MAX: cfg_q.inner_duty_max <= pwdata[15:0];
				dcpvr_pkg::REG_INNER_DUTY_MIN: cfg_q.inner_duty_min <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dcpvr_pkg::REG_TARGET_LOW:     prdata = {16'd0, cfg_q.target_low};
			dcpvr_pkg::REG_TARGET_MID:     prdata = {16'd0, cfg_q.target_mid};
			dcpvr_pkg::REG_TARGET_HIGH:    prdata = {16'd0, cfg_q.target_high};
			dcpvr_pkg::REG_TARGET_PREFIRE: prdata = {16'd0, cfg_q.target_prefire};
			dcpvr_pkg::REG_EXT_TARGET:     prdata = {16'd0, cfg_q.ext_target};
			dcpvr_pkg::REG_RMS_MODE:       prdata = {30'd0, cfg_q.rms_mode};
			dcpvr_pkg::REG_INNER_DUTY_MAX: prdata = {16'd0, cfg_q.inner_duty_max};
			dcpvr_pkg::REG_INNER_DUTY_MIN: prdata = {16'd0, cfg_q.inner_duty_min};
			default:                       prdata = '0;
		endcase
	end

	dcpvr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	dcpvr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_cmd)
	);

	dcpvr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_cmd       (pop_cmd),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

// ===== hw/rtl/dcpvr_checker.sv =====
// Port-level checks for the dual-channel PWM voltage regulator.
// Depends on dcpvr_pkg; bound to the top level below.
`timescale 1ns / 1ps

module dcpvr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[35:34] != 2'd3)
		else $error("illegal channel mode");

	a_adjust_needs_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35:34] == dcpvr_pkg::MODE_INNER |-> !m_tdata[36])
		else $error("external adjust requested in inner-only mode");

	a_ext_duty_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:16] <= dcpvr_pkg::EXT_DUTY_MAX)
		else $error("external duty above its limit");

endmodule

bind dual_channel_pwm_voltage_regulator dcpvr_checker u_checker (.*);

// ===== tb/sv/dual_channel_pwm_voltage_regulator_test.sv =====
// Self-checking testbench for the dual-channel PWM voltage regulator.
// A table of directed commands and then randomized phases under several register settings are
// checked against set results or a built-in duty predictor; it depends on dcpvr_pkg and the RTL.
`timescale 1ns / 1ps

module dual_channel_pwm_voltage_regulator_test;
	import dcpvr_pkg::*;

	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int QUIET_LIMIT = 20000;
	localparam int LONG_HOLD = 600;
	localparam int HOLD_AFTER = 400;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 114;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int SETTLE_CYCLES = 160;

	typedef struct packed {
		logic        adjust;
		logic [1:0]  mode;
		logic        ext_on;
		logic        inner_on;
		logic [15:0] ext_duty;
		logic [15:0] inner_duty;
	} duty_report_t;

	typedef struct packed {
		logic [1:0]   kind;
		logic         prefire;
		logic [1:0]   level;
		logic [15:0]  vin;
		logic [15:0]  vext;
		logic         typed;
		duty_report_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // prefire, power_level, inner_voltage, ext_voltage
	logic [1:0]  s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // inner_duty, ext_duty, inner_on, ext_on, channel_mode,
	                        // ext_adjust_request
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dual_channel_pwm_voltage_regulator uut (.*);

	cfg_t         shadow_cfg;
	logic [1:0]   run_mode;
	logic [15:0]  inner_target_now;
	logic [15:0]  ext_target_now;
	logic [15:0]  inner_duty_now;
	logic [15:0]  ext_duty_now;
	logic         inner_firing_now;
	logic         ext_firing_now;

	duty_report_t pending_reports[$];
	stim_row_t    directed_rows[$];
	int unsigned  mismatches = 0;
	int unsigned  reports_seen = 0;
	int unsigned  quiet_cycles = 0;
	bit           calm = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 9) begin
			return 0;
		end else if (r < 15) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [15:0] feedforward_duty(input logic [15:0] target,
		input logic [15:0] measured, input logic [15:0] period, input logic rms,
		input logic [15:0] dmax, input logic [15:0] dmin);
		longint unsigned d;
		if (measured == 16'd0) begin
			return dmax;
		end
		d = (64'(target) * 64'(period)) / 64'(measured);
		if (d > 64'hFFFF) begin
			return dmax;
		end
		if (rms) begin
			d = (d * 64'(target)) / 64'(measured);
			if (d > 64'hFFFF) begin
				return dmax;
			end
		end
		if (d >= 64'(dmax)) begin
			return dmax;
		end
		if (d < 64'(dmin)) begin
			return dmin;
		end
		return d[15:0];
	endfunction

	function automatic duty_report_t predict_report(input logic [1:0] kind, input logic prefire,
		input logic [1:0] level, input logic [15:0] vin, input logic [15:0] vext);
		duty_report_t rpt;
		logic         inner_active;
		logic         ext_active;
		logic         adjust;
		adjust = 1'b0;
		if (kind == KIND_START) begin
			if (CHANNELS_FITTED == 1) begin
				run_mode = MODE_INNER;
			end else if (CHANNELS_FITTED == 2) begin
				run_mode = MODE_EXT;
			end else if (run_mode == MODE_INNER) begin
				run_mode = MODE_EXT;
			end else if (run_mode == MODE_EXT) begin
				run_mode = MODE_BOTH;
			end else begin
				run_mode = MODE_INNER;
			end
		end
		inner_active = (run_mode != MODE_EXT);
		ext_active = (run_mode == MODE_EXT) || (run_mode == MODE_BOTH);
		case (kind)
			KIND_START: begin
				if (inner_active) begin
					inner_duty_now = INNER_PERIOD >> 1;
					if (prefire) begin
						inner_target_now = shadow_cfg.target_prefire;
					end else if (level == LEVEL_LOW) begin
						inner_target_now = shadow_cfg.target_low;
					end else if (level == LEVEL_MID) begin
						inner_target_now = shadow_cfg.target_mid;
					end else if (level == LEVEL_HIGH) begin
						inner_target_now = shadow_cfg.target_high;
					end
					inner_firing_now = 1'b1;
				end
				if (ext_active) begin
					ext_duty_now = EXT_PERIOD >> 1;
					ext_target_now = shadow_cfg.ext_target;
					ext_firing_now = 1'b1;
					adjust = 1'b1;
				end
			end
			KIND_CONTROL: begin
				if (inner_active) begin
					inner_duty_now = feedforward_duty(inner_target_now, vin, INNER_PERIOD,
						shadow_cfg.rms_mode[0], shadow_cfg.inner_duty_max,
						shadow_cfg.inner_duty_min);
				end
				if (ext_active) begin
					ext_duty_now = feedforward_duty(ext_target_now, vext, EXT_PERIOD,
						shadow_cfg.rms_mode[1], EXT_DUTY_MAX, EXT_DUTY_MIN);
					adjust = 1'b1;
				end
			end
			KIND_STOP: begin
				if (inner_active) begin
					inner_duty_now = 16'd0;
					inner_firing_now = 1'b0;
				end
				if (ext_active) begin
					ext_duty_now = 16'd0;
					ext_firing_now = 1'b0;
				end
			end
			default: begin
			end
		endcase
		rpt.inner_duty = inner_duty_now;
		rpt.ext_duty = ext_duty_now;
		rpt.inner_on = inner_firing_now;
		rpt.ext_on = ext_firing_now;
		rpt.mode = run_mode;
		rpt.adjust = adjust;
		return rpt;
	endfunction

	function automatic duty_report_t report(input logic [15:0] inner_duty,
		input logic [15:0] ext_duty, input logic inner_on, input logic ext_on,
		input logic [1:0] mode, input logic adjust);
		duty_report_t rpt;
		rpt.inner_duty = inner_duty;
		rpt.ext_duty = ext_duty;
		rpt.inner_on = inner_on;
		rpt.ext_on = ext_on;
		rpt.mode = mode;
		rpt.adjust = adjust;
		return rpt;
	endfunction

	function automatic stim_row_t make_row(input logic [1:0] kind, input logic prefire,
		input logic [1:0] level, input logic [15:0] vin, input logic [15:0] vext,
		input logic typed, input duty_report_t want);
		stim_row_t row;
		row.kind = kind;
		row.prefire = prefire;
		row.level = level;
		row.vin = vin;
		row.vext = vext;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic logic [15:0] pick_voltage(input logic [15:0] target);
		int unsigned r;
		int unsigned v;
		v = 32'(target);
		r = $urandom_range(0, 19);
		if (r < 9) begin
			v = v + $urandom_range(0, v);
		end else if (r < 11) begin
			v = $urandom_range(v / 2, v);
		end else if (r < 13) begin
			v = 0;
		end else if (r < 14) begin
			v = 65535;
		end else if (r < 16) begin
			v = $urandom_range(1, 15);
		end else begin
			v = $urandom_range(0, 65535);
		end
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	task automatic send_command(input logic [1:0] kind, input logic prefire,
		input logic [1:0] level, input logic [15:0] vin, input logic [15:0] vext,
		input logic typed, input duty_report_t want);
		int unsigned  gap;
		duty_report_t predicted;
		gap = calm ? 0 : gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {5'd0, vext, vin, level, prefire};
		do @(posedge clk); while (!s_tready);
		predicted = predict_report(kind, prefire, level, vin, vext);
		pending_reports.push_back(typed ? want : predicted);
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET_LOW:     shadow_cfg.target_low = value;
			REG_TARGET_MID:     shadow_cfg.target_mid = value;
			REG_TARGET_HIGH:    shadow_cfg.target_high = value;
			REG_TARGET_PREFIRE: shadow_cfg.target_prefire = value;
			REG_EXT_TARGET:     shadow_cfg.ext_target = value;
			REG_RMS_MODE:       shadow_cfg.rms_mode = value[1:0];
			REG_INNER_DUTY_MAX: shadow_cfg.inner_duty_max = value;
			default:            shadow_cfg.inner_duty_min = value;
		endcase
	endtask

	task automatic write_settings(input logic [15:0] low, input logic [15:0] mid,
		input logic [15:0] high, input logic [15:0] prefire, input logic [15:0] ext,
		input logic [15:0] rms, input logic [15:0] dmax, input logic [15:0] dmin);
		write_register(REG_TARGET_LOW, low);
		write_register(REG_TARGET_MID, mid);
		write_register(REG_TARGET_HIGH, high);
		write_register(REG_TARGET_PREFIRE, prefire);
		write_register(REG_EXT_TARGET, ext);
		write_register(REG_RMS_MODE, rms);
		write_register(REG_INNER_DUTY_MAX, dmax);
		write_register(REG_INNER_DUTY_MIN, dmin);
	endtask

	task automatic check_report(input duty_report_t got);
		duty_report_t want;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES) begin
				$display("unexpected result: inner_duty %0d ext_duty %0d on %b%b mode %0d adj %b",
					got.inner_duty, got.ext_duty, got.inner_on, got.ext_on, got.mode,
					got.adjust);
			end
		end else begin
			want = pending_reports.pop_front();
			if (got.inner_duty !== want.inner_duty || got.ext_duty !== want.ext_duty ||
				got.inner_on !== want.inner_on || got.ext_on !== want.ext_on ||
				got.mode !== want.mode || got.adjust !== want.adjust) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES) begin
					$display("result %0d: expected inner_duty %0d ext_duty %0d on %b%b mode %0d adj %b",
						reports_seen, want.inner_duty, want.ext_duty, want.inner_on,
						want.ext_on, want.mode, want.adjust);
					$display("result %0d: actual   inner_duty %0d ext_duty %0d on %b%b mode %0d adj %b",
						reports_seen, got.inner_duty, got.ext_duty, got.inner_on,
						got.ext_on, got.mode, got.adjust);
				end
			end
		end
	endtask

	// The receiver stalls at random outside the calm phases and once holds off long enough to back up the input.
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (m_tvalid && m_tready) begin
					check_report(m_tdata[36:0]);
					reports_seen++;
				end
				if (!hold_done && reports_seen >= HOLD_AFTER) begin
					hold_done = 1;
					hold_left = LONG_HOLD;
				end
				if (hold_left == 0 && !calm && $urandom_range(0, 2) == 0) begin
					hold_left = gap_length();
				end
				if (hold_left > 0) begin
					hold_left--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		stim_row_t    row;
		duty_report_t none;
		logic [1:0]   kind;
		int unsigned  r;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		none = '0;

		shadow_cfg.target_low = RST_TARGET_LOW;
		shadow_cfg.target_mid = RST_TARGET_MID;
		shadow_cfg.target_high = RST_TARGET_HIGH;
		shadow_cfg.target_prefire = RST_TARGET_PREFIRE;
		shadow_cfg.ext_target = RST_EXT_TARGET;
		shadow_cfg.rms_mode = 2'd0;
		shadow_cfg.inner_duty_max = RST_INNER_DUTY_MAX;
		shadow_cfg.inner_duty_min = 16'd0;
		run_mode = MODE_BOTH;
		inner_target_now = RST_TARGET_LOW;
		ext_target_now = 16'd0;
		inner_duty_now = 16'd0;
		ext_duty_now = 16'd0;
		inner_firing_now = 1'b0;
		ext_firing_now = 1'b0;

		// The reset defaults apply: targets 3300/3600/3900/2000/3600 and a 0..1024 clamp.
		directed_rows.push_back(make_row(KIND_UNKNOWN, 1'b1, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1,
			report(16'd0, 16'd0, 1'b0, 1'b0, MODE_BOTH, 1'b0)));
		directed_rows.push_back(make_row(KIND_STOP, 1'b0, LEVEL_LOW, 16'd0, 16'd0, 1'b1,
			report(16'd0, 16'd0, 1'b0, 1'b0, MODE_BOTH, 1'b0)));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd0, 16'd0, 1'b1,
			report(16'd1024, 16'd1024, 1'b0, 1'b0, MODE_BOTH, 1'b1)));
		directed_rows.push_back(make_row(KIND_START, 1'b0, LEVEL_LOW, 16'd0, 16'd0, 1'b1,
			report(16'd512, 16'd1024, 1'b1, 1'b0, MODE_INNER, 1'b0)));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'hFFFF, 16'd0, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b1, 2'd3, 16'd1, 16'hFFFF, 1'b1,
			report(16'd1024, 16'd1024, 1'b1, 1'b0, MODE_INNER, 1'b0)));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_MID, 16'd6600, 16'd1, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_START, 1'b1, 2'd3, 16'd0, 16'd0, 1'b0, none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd0, 16'd3600, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd100, 16'd0, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd0, 16'hFFFF, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_STOP, 1'b1, LEVEL_HIGH, 16'd0, 16'd0, 1'b0, none));
		directed_rows.push_back(make_row(KIND_START, 1'b1, LEVEL_HIGH, 16'd0, 16'd0, 1'b1,
			report(16'd512, 16'd512, 1'b1, 1'b1, MODE_BOTH, 1'b1)));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd2000, 16'd7200,
			1'b0, none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd4000, 16'd3601,
			1'b0, none));
		directed_rows.push_back(make_row(KIND_UNKNOWN, 1'b0, LEVEL_MID, 16'd1, 16'd1, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_STOP, 1'b0, LEVEL_LOW, 16'd0, 16'd0, 1'b1,
			report(16'd0, 16'd0, 1'b0, 1'b0, MODE_BOTH, 1'b0)));
		directed_rows.push_back(make_row(KIND_START, 1'b0, 2'd3, 16'd0, 16'd0, 1'b0, none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd4000, 16'd0, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_START, 1'b0, LEVEL_MID, 16'd0, 16'd0, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_START, 1'b0, LEVEL_HIGH, 16'd0, 16'd0, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd3900, 16'd3600,
			1'b0, none));
		directed_rows.push_back(make_row(KIND_CONTROL, 1'b0, LEVEL_LOW, 16'd7800, 16'd1, 1'b0,
			none));
		directed_rows.push_back(make_row(KIND_STOP, 1'b0, LEVEL_LOW, 16'd0, 16'd0, 1'b1,
			report(16'd0, 16'd0, 1'b0, 1'b0, MODE_BOTH, 1'b0)));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_command(row.kind, row.prefire, row.level, row.vin, row.vext, row.typed,
				row.want);
		end
		drain_reports();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
				end
				1: write_settings(16'd3000, 16'd3600, 16'd4200, 16'd1500, 16'd3300, 16'd3,
					16'd1024, 16'd100);
				2: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1,
					16'hFFFF, 16'd0);
				3: write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd0, 16'hFFFF);
				4: write_settings(16'd2500, 16'd3300, 16'd5000, 16'd800, 16'd4000, 16'd0,
					16'd100, 16'hFFFF);
				default: write_settings(16'($urandom_range(200, 9000)),
					16'($urandom_range(200, 9000)), 16'($urandom_range(200, 9000)),
					16'($urandom_range(200, 9000)), 16'($urandom_range(200, 9000)),
					16'($urandom_range(0, 3)),
					16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(300, 1024)),
					16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 300)));
			endcase
			calm = (phase % 3 == 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					kind = KIND_START;
				end else if (r < 82) begin
					kind = KIND_CONTROL;
				end else if (r < 93) begin
					kind = KIND_STOP;
				end else begin
					kind = KIND_UNKNOWN;
				end
				send_command(kind, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					pick_voltage(inner_target_now), pick_voltage(ext_target_now), 1'b0, none);
			end
			drain_reports();
		end

		calm = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dcpvr_pkg.sv
hw/rtl/dcpvr_front.sv
hw/rtl/dcpvr_queue.sv
hw/rtl/dcpvr_div.sv
hw/rtl/dcpvr_back.sv
hw/rtl/dual_channel_pwm_voltage_regulator.sv
hw/rtl/dcpvr_checker.sv
tb/sv/dual_channel_pwm_voltage_regulator_test.sv
